@@ hw/rtl/clm_pkg.sv @@
// shared types and constants for the circular list manager
`timescale 1ns / 1ps

package clm_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_FIND     = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAKE_RD,
    S_TAKE_WT,
    S_INS_NODE,
    S_INS_LINK,
    S_SRCH_RD,
    S_SRCH,
    S_REM_LINK,
    S_REM_FREE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             found;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             we_val;
    logic             we_link;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_val;
    logic [IDX_W-1:0] wr_link;
  } mem_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] rd_val;
    logic [IDX_W-1:0] rd_link;
  } mem_rsp_t;

endpackage

@@ hw/rtl/clm_store.sv @@
// node store: value and link memories, one write and one registered read per cycle
`timescale 1ns / 1ps

module clm_store (
  input  logic              clk,
  input  clm_pkg::mem_req_t req,
  output clm_pkg::mem_rsp_t rsp
);
  import clm_pkg::*;

  logic [VAL_W-1:0] vals  [DEPTH];
  logic [IDX_W-1:0] links [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we_val) begin
      vals[req.wr_addr] <= req.wr_val;
    end
    if (req.we_link) begin
      links[req.wr_addr] <= req.wr_link;
    end
    rsp.rd_val  <= vals[req.rd_addr];
    rsp.rd_link <= links[req.rd_addr];
  end

endmodule

@@ hw/rtl/clm_ctrl.sv @@
// list sequencer: head, tail, free list and the walk over the node store
`timescale 1ns / 1ps

module clm_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                operation,
  input  logic signed [31:0]        value,
  output logic                      res_valid,
  input  logic                      res_ready,
  output clm_pkg::res_t             res,
  output clm_pkg::mem_req_t         mem_req,
  input  clm_pkg::mem_rsp_t         mem_rsp
);
  import clm_pkg::*;

  state_t state, state_next;

  logic [IDX_W-1:0] head, tail, free_head, slot, cur, prev, nxt;
  logic [CNT_W-1:0] cnt, free_cnt, fresh, n;
  logic [2:0]       op;
  logic [VAL_W-1:0] key;
  logic             found;
  stat_t            status;

  logic accept, match, last_node, free_avail, fresh_avail, is_remove;

  assign accept      = in_valid && in_ready;
  assign match       = mem_rsp.rd_val == key;
  assign last_node   = n == (cnt - CNT_W'(1));
  assign free_avail  = free_cnt != '0;
  assign fresh_avail = fresh != CNT_W'(DEPTH);
  assign is_remove   = op == OP_REMOVE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (operation)
            OP_INS_HEAD, OP_INS_TAIL: begin
              if (free_avail) state_next = S_TAKE_RD;
              else if (fresh_avail) state_next = S_INS_NODE;
              else state_next = S_DONE;
            end
            OP_REMOVE, OP_FIND: begin
              state_next = (cnt == '0) ? S_DONE : S_SRCH_RD;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_TAKE_RD:  state_next = S_TAKE_WT;
      S_TAKE_WT:  state_next = S_INS_NODE;
      S_INS_NODE: state_next = (cnt == '0) ? S_DONE : S_INS_LINK;
      S_INS_LINK: state_next = S_DONE;
      S_SRCH_RD:  state_next = S_SRCH;
      S_SRCH: begin
        if (match) begin
          if (!is_remove) state_next = S_DONE;
          else if (cnt == CNT_W'(1)) state_next = S_REM_FREE;
          else state_next = S_REM_LINK;
        end else if (last_node) begin
          state_next = S_DONE;
        end
      end
      S_REM_LINK: state_next = S_REM_FREE;
      S_REM_FREE: state_next = S_DONE;
      S_DONE:     if (res_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs and memory requests
  always_comb begin
    in_ready        = state == S_IDLE;
    res_valid       = state == S_DONE;
    res.found       = found;
    res.status      = status;
    res.count       = cnt;
    mem_req.rd_addr = cur;
    mem_req.we_val  = 1'b0;
    mem_req.we_link = 1'b0;
    mem_req.wr_addr = cur;
    mem_req.wr_val  = key;
    mem_req.wr_link = free_head;
    case (state)
      S_TAKE_RD: mem_req.rd_addr = free_head;
      S_INS_NODE: begin
        mem_req.we_val  = 1'b1;
        mem_req.we_link = 1'b1;
        mem_req.wr_addr = slot;
        mem_req.wr_link = (cnt == '0) ? slot : head;
      end
      S_INS_LINK: begin
        mem_req.we_link = 1'b1;
        mem_req.wr_addr = tail;
        mem_req.wr_link = slot;
      end
      S_SRCH: begin
        // chase the link straight from the read data, one node per cycle
        if (!match && !last_node) mem_req.rd_addr = mem_rsp.rd_link;
      end
      S_REM_LINK: begin
        mem_req.we_link = 1'b1;
        if (cur == head) begin
          mem_req.wr_addr = tail;
          mem_req.wr_link = nxt;
        end else if (cur == tail) begin
          mem_req.wr_addr = prev;
          mem_req.wr_link = head;
        end else begin
          mem_req.wr_addr = prev;
          mem_req.wr_link = nxt;
        end
      end
      S_REM_FREE: begin
        mem_req.we_link = 1'b1;
        mem_req.wr_addr = cur;
        mem_req.wr_link = free_head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      free_head <= '0;
      free_cnt  <= '0;
      fresh     <= '0;
      found     <= 1'b0;
      status    <= STAT_OK;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= operation;
            key    <= value;
            cur    <= head;
            prev   <= tail;
            n      <= '0;
            found  <= 1'b0;
            status <= STAT_OK;
            case (operation)
              OP_INS_HEAD, OP_INS_TAIL: begin
                if (!free_avail) begin
                  if (fresh_avail) begin
                    slot  <= fresh[IDX_W-1:0];
                    fresh <= fresh + CNT_W'(1);
                  end else begin
                    status <= STAT_FULL;
                  end
                end
              end
              OP_REMOVE, OP_FIND: begin
                if (cnt == '0) status <= STAT_ABSENT;
              end
              OP_CLEAR: begin
                head      <= '0;
                tail      <= '0;
                cnt       <= '0;
                free_head <= '0;
                free_cnt  <= '0;
                fresh     <= '0;
              end
              default: ;
            endcase
          end
        end
        S_TAKE_WT: begin
          slot      <= free_head;
          free_head <= mem_rsp.rd_link;
          free_cnt  <= free_cnt - CNT_W'(1);
        end
        S_INS_NODE: begin
          if (cnt == '0) begin
            head <= slot;
            tail <= slot;
            cnt  <= cnt + CNT_W'(1);
          end
        end
        S_INS_LINK: begin
          if (op == OP_INS_HEAD) head <= slot;
          else tail <= slot;
          cnt <= cnt + CNT_W'(1);
        end
        S_SRCH: begin
          if (match) begin
            found <= 1'b1;
            nxt   <= mem_rsp.rd_link;
          end else if (last_node) begin
            status <= STAT_ABSENT;
          end else begin
            prev <= cur;
            cur  <= mem_rsp.rd_link;
            n    <= n + CNT_W'(1);
          end
        end
        S_REM_LINK: begin
          if (cur == head) head <= nxt;
          else if (cur == tail) tail <= prev;
        end
        S_REM_FREE: begin
          free_head <= cur;
          free_cnt  <= free_cnt + CNT_W'(1);
          cnt       <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            head <= '0;
            tail <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/circular_list_manager.sv @@
// accept to out_valid: insert pops the free list or takes a fresh node, writes it, then links
// it unless the list was empty; find and remove walk up to 256 nodes, one link read per cycle;
// remove relinks and frees it; a full insert, clear, spare codes, empty-list search go to done
// throughput: one item at a time; the next item is taken once the result moves to the
// output register, which may still wait on out_ready
// synchronous reset empties the list and free list; node memories are not cleared
`timescale 1ns / 1ps

module circular_list_manager (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  operation,
  input  logic signed [31:0]          value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [1:0]                  status,
  output logic [clm_pkg::CNT_W-1:0]   count
);
  import clm_pkg::*;

  res_t     res;
  logic     res_valid, res_ready;
  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  clm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp)
  );

  clm_store u_store (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  // output register parts the sequencer from the consumer
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      found  <= res.found;
      status <= res.status;
      count  <= res.count;
    end
  end

endmodule
